// File: sv/vpzm_pkg.sv
`default_nettype none
package vpzm_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CW        = 24;
	localparam int AIW       = 25;
	localparam int SCR_W     = 13;
	localparam int SC_W      = 32;
	localparam int FAC_W     = 24;
	localparam int MA_W      = 27;
	localparam int MB_W      = 33;
	localparam int PW        = 60;
	localparam int DVS_W     = 34;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int REQ_W     = 3;

	localparam logic [REQ_W-1:0] REQ_SETVP = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PANZ  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_W2PX  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_W2PY  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_P2WX  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_P2WY  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_SW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WB   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAXZ = 3'd6;

	localparam logic [SCR_W-1:0] SW_RST   = 13'd800;
	localparam logic [SCR_W-1:0] SH_RST   = 13'd600;
	localparam logic [CW-1:0]    WL_RST   = 24'd0;
	localparam logic [CW-1:0]    WT_RST   = 24'd0;
	localparam logic [CW-1:0]    WR_RST   = 24'd120000;
	localparam logic [CW-1:0]    WB_RST   = 24'd90000;
	localparam logic [SC_W-1:0]  MAXZ_RST = 32'd16777216;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SETVP, OP_DIV, OP_STORE, OP_MUL, OP_ZSEL,
		OP_CLR, OP_CLL, OP_CLC, OP_PLACE, OP_CONV, OP_OUT
	} dp_op_t;

	typedef enum logic [2:0] {
		DS_ZX, DS_ZY, DS_LO, DS_HI, DS_PXS, DS_PYS, DS_WXS, DS_WYS
	} div_sel_t;

	typedef enum logic [1:0] {
		MS_ZOOM, MS_CENTER, MS_CONV
	} mul_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t dsel;
		mul_sel_t msel;
		logic     axis;
	} dp_cmd_t;

	typedef struct packed {
		logic             div_done;
		logic [REQ_W-1:0] req;
		logic             vp_bad;
		logic             ign;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_SETVP, ST_DIV, ST_DWAIT, ST_ZMUL, ST_ZSEL, ST_CMUL,
		ST_CLR, ST_CLL, ST_CLC, ST_PLACE, ST_VMUL, ST_CONV, ST_DONE
	} state_t;

	function automatic logic signed [CW-1:0] sat_cw(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
		lo = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};
		if (v > hi) begin
			return hi[CW-1:0];
		end else if (v < lo) begin
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] sat_pix(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'(32767);
		lo = -PW'(32767);
		if (v > hi) begin
			return hi[CW-1:0];
		end else if (v < lo) begin
			return lo[CW-1:0];
		end
		return v[CW-1:0];
	endfunction

endpackage
`default_nettype wire

// File: sv/vpzm_div.sv
`default_nettype none
module vpzm_div #(
	parameter int DVD_W = 60,
	parameter int DVS_W = 34
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0]      quotient,
	output logic                  done
);
	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W+1:0] diff;
	logic             qbit;

	// Restoring division, one quotient bit per cycle. A zero divisor gives all ones.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		qbit  = ~diff[DVS_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule
`default_nettype wire

// File: sv/vpzm_dp.sv
`default_nettype none
module vpzm_dp #(
	parameter int FRAC_BITS = vpzm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire vpzm_pkg::dp_cmd_t                  cmd,
	output vpzm_pkg::dp_stat_t                      stat,
	input  wire logic [vpzm_pkg::REQ_W-1:0]         req_type,
	input  wire logic signed [vpzm_pkg::AIW-1:0]    coord_a,
	input  wire logic signed [vpzm_pkg::AIW-1:0]    coord_b,
	input  wire logic signed [vpzm_pkg::CW-1:0]     coord_c,
	input  wire logic signed [vpzm_pkg::CW-1:0]     coord_d,
	input  wire logic [vpzm_pkg::FAC_W-1:0]         zoom_factor,
	input  wire logic                               fit_world,
	input  wire logic                               ignore_borders,
	input  wire logic                               cfg_we,
	input  wire logic [vpzm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [vpzm_pkg::CFG_W-1:0]         cfg_data,
	output logic signed [vpzm_pkg::CW-1:0]          result_coord,
	output logic signed [vpzm_pkg::CW-1:0]          view_left,
	output logic signed [vpzm_pkg::CW-1:0]          view_top,
	output logic signed [vpzm_pkg::CW-1:0]          view_right,
	output logic signed [vpzm_pkg::CW-1:0]          view_bottom,
	output logic                                    bad_request
);
	import vpzm_pkg::*;

	localparam int AW = FRAC_BITS + 18;
	localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

	// Configuration.
	logic [SCR_W-1:0]     sw_q, sh_q;
	logic signed [CW-1:0] wl_q, wt_q, wr_q, wb_q;
	logic [SC_W-1:0]      maxz_q;

	// Captured item.
	logic [REQ_W-1:0]      req_q;
	logic signed [AIW-1:0] ca_q, cb_q;
	logic signed [CW-1:0]  cc_q, cd_q;
	logic [FAC_W-1:0]      fac_q;
	logic                  full_q, ign_q;

	// Viewport and scales.
	logic signed [CW-1:0] vpl_q, vpt_q, vpr_q, vpb_q;
	logic [SC_W-1:0]      pxs_q, pys_q, wxs_q, wys_q;

	// Working registers.
	logic [SC_W-1:0]      zmin_q, z_q;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] lo_q, hi_q;
	logic                 neg_q;
	logic signed [CW-1:0] res_q;
	logic                 bad_q;

	logic signed [CW:0]   dx, dy, wdx, wdy;
	logic [CW-1:0]        ux, uy;
	logic [CW-1:0]        num, den;
	logic                 place;
	logic signed [PW-1:0] zs, ss, pn;
	logic [PW-1:0]        dvd;
	logic [DVS_W-1:0]     dvs;
	logic [PW-1:0]        quo;
	logic                 div_done;
	logic [SC_W-1:0]      qsat, zyv;
	logic [PW-1:0]        pv;
	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic [PW-1:0]        zr;
	logic [SC_W-1:0]      zc;
	logic signed [AW-1:0] whi, wlo, cdiff, chalf;
	logic signed [PW-1:0] ct, cr;
	logic signed [CW-1:0] cres, sl, st;
	logic                 vp_bad;

	always_comb begin
		dx  = (CW+1)'(vpr_q) - (CW+1)'(vpl_q);
		dy  = (CW+1)'(vpb_q) - (CW+1)'(vpt_q);
		wdx = (CW+1)'(wr_q) - (CW+1)'(wl_q);
		wdy = (CW+1)'(wb_q) - (CW+1)'(wt_q);
		ux  = (dx > 0) ? dx[CW-1:0] : '0;
		uy  = (dy > 0) ? dy[CW-1:0] : '0;
	end

	// Divider operand selection.
	always_comb begin
		num   = '0;
		den   = '0;
		place = 1'b0;
		case (cmd.dsel)
			DS_ZX:  begin num = CW'(sw_q); den = wdx[CW-1:0]; end
			DS_ZY:  begin num = CW'(sh_q); den = wdy[CW-1:0]; end
			DS_PXS: begin num = CW'(sw_q); den = ux; end
			DS_PYS: begin num = CW'(sh_q); den = uy; end
			DS_WXS: begin num = ux; den = CW'(sw_q); end
			DS_WYS: begin num = uy; den = CW'(sh_q); end
			DS_LO, DS_HI: place = 1'b1;
			default: place = 1'b0;
		endcase
		zs = $signed(PW'(z_q));
		ss = $signed(PW'(cmd.axis ? sh_q : sw_q) << FRAC_BITS);
		pn = (cmd.dsel == DS_LO) ? (prod_q + zs - ss) : (prod_q + zs + ss);
		if (place) begin
			// Floor division of a negative value: floor(n/d) = ~(~n / d).
			dvd = pn[PW-1] ? ~pn : pn;
			dvs = {1'b0, z_q, 1'b0};
		end else begin
			dvd = (PW'(num) << FRAC_BITS) + PW'(den >> 1);
			dvs = DVS_W'(den);
		end
	end

	vpzm_div #(
		.DVD_W(PW),
		.DVS_W(DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_DIV),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quo),
		.done     (div_done)
	);

	always_comb begin
		qsat = (|quo[PW-1:SC_W]) ? '1 : quo[SC_W-1:0];
		pv   = neg_q ? ~quo : quo;
		zyv  = (wdy <= 0) ? '1 : qsat;
	end

	// Multiplier operands.
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.msel)
			MS_ZOOM: begin
				ma = $signed(MA_W'(fac_q));
				mb = $signed({1'b0, pys_q});
			end
			MS_CENTER: begin
				ma = cmd.axis ? MA_W'(cb_q) : MA_W'(ca_q);
				mb = $signed({1'b0, z_q});
			end
			MS_CONV: begin
				case (req_q)
					REQ_W2PX: begin
						ma = MA_W'(ca_q) - MA_W'(vpl_q);
						mb = $signed({1'b0, pxs_q});
					end
					REQ_W2PY: begin
						ma = MA_W'(ca_q) - MA_W'(vpt_q);
						mb = $signed({1'b0, pys_q});
					end
					REQ_P2WX: begin
						ma = MA_W'(ca_q);
						mb = $signed({1'b0, wxs_q});
					end
					default: begin
						ma = $signed(MA_W'(sh_q)) - MA_W'(ca_q);
						mb = $signed({1'b0, wys_q});
					end
				endcase
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Zoom selection, border clamping, conversion results and the set viewport check.
	always_comb begin
		zr = ($unsigned(prod_q) + HALF) >> FRAC_BITS;
		zc = (zr > PW'(maxz_q)) ? maxz_q : zr[SC_W-1:0];
		if (!ign_q && zc < zmin_q) begin
			zc = zmin_q;
		end
		if (full_q) begin
			zc = zmin_q;
		end
		if (zc == '0) begin
			zc = SC_W'(1);
		end

		whi   = cmd.axis ? AW'(wb_q) : AW'(wr_q);
		wlo   = cmd.axis ? AW'(wt_q) : AW'(wl_q);
		cdiff = (hi_q - lo_q) - (whi - wlo);
		chalf = cdiff >>> 1;

		ct = (req_q == REQ_W2PY) ? ($signed(PW'(sh_q) << FRAC_BITS) - prod_q) : prod_q;
		cr = (ct + $signed(HALF)) >>> FRAC_BITS;
		case (req_q)
			REQ_W2PX, REQ_W2PY: cres = sat_pix(cr);
			REQ_P2WX:           cres = sat_cw(cr + PW'(vpl_q));
			default:            cres = sat_cw(cr + PW'(vpt_q));
		endcase

		sl     = sat_cw(PW'(ca_q));
		st     = sat_cw(PW'(cb_q));
		vp_bad = (sl == cc_q) || (st == cd_q);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= SW_RST;
			sh_q   <= SH_RST;
			wl_q   <= WL_RST;
			wt_q   <= WT_RST;
			wr_q   <= WR_RST;
			wb_q   <= WB_RST;
			maxz_q <= MAXZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SW:   sw_q   <= cfg_data[SCR_W-1:0];
				CFG_SH:   sh_q   <= cfg_data[SCR_W-1:0];
				CFG_WL:   wl_q   <= cfg_data[CW-1:0];
				CFG_WT:   wt_q   <= cfg_data[CW-1:0];
				CFG_WR:   wr_q   <= cfg_data[CW-1:0];
				CFG_WB:   wb_q   <= cfg_data[CW-1:0];
				CFG_MAXZ: maxz_q <= cfg_data[SC_W-1:0];
				default: ;
			endcase
		end
	end

	// Viewport and scale state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpl_q <= '0;
			vpt_q <= '0;
			vpr_q <= '0;
			vpb_q <= '0;
			pxs_q <= '0;
			pys_q <= '0;
			wxs_q <= '0;
			wys_q <= '0;
		end else begin
			case (cmd.op)
				OP_SETVP: begin
					if (!vp_bad) begin
						vpl_q <= (sl < cc_q) ? sl : cc_q;
						vpr_q <= (sl < cc_q) ? cc_q : sl;
						vpt_q <= (st < cd_q) ? st : cd_q;
						vpb_q <= (st < cd_q) ? cd_q : st;
					end
				end
				OP_STORE: begin
					case (cmd.dsel)
						DS_PXS: pxs_q <= qsat;
						DS_PYS: pys_q <= qsat;
						DS_WXS: wxs_q <= qsat;
						DS_WYS: wys_q <= qsat;
						default: ;
					endcase
				end
				OP_PLACE: begin
					if (cmd.axis) begin
						vpt_q <= sat_cw(PW'(lo_q));
						vpb_q <= sat_cw(PW'(hi_q));
					end else begin
						vpl_q <= sat_cw(PW'(lo_q));
						vpr_q <= sat_cw(PW'(hi_q));
					end
				end
				default: ;
			endcase
		end
	end

	// Item capture, working registers and output registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				req_q  <= req_type;
				ca_q   <= coord_a;
				cb_q   <= coord_b;
				cc_q   <= coord_c;
				cd_q   <= coord_d;
				fac_q  <= zoom_factor;
				full_q <= fit_world;
				ign_q  <= ignore_borders;
				res_q  <= '0;
				bad_q  <= 1'b0;
			end
			OP_SETVP: bad_q <= vp_bad;
			OP_DIV:   neg_q <= place & pn[PW-1];
			OP_STORE: begin
				case (cmd.dsel)
					DS_ZX: zmin_q <= (wdx <= 0) ? '1 : qsat;
					DS_ZY: zmin_q <= (zyv < zmin_q) ? zyv : zmin_q;
					DS_LO: lo_q   <= pv[AW-1:0];
					DS_HI: hi_q   <= pv[AW-1:0];
					default: ;
				endcase
			end
			OP_MUL:  prod_q <= ma * mb;
			OP_ZSEL: z_q    <= zc;
			OP_CLR: begin
				if (hi_q > whi) begin
					lo_q <= lo_q + (whi - hi_q);
					hi_q <= whi;
				end
			end
			OP_CLL: begin
				if (lo_q < wlo) begin
					hi_q <= hi_q + (wlo - lo_q);
					lo_q <= wlo;
				end
			end
			OP_CLC: begin
				// A viewport wider than the world is shifted back by half the excess.
				if (cdiff > 0) begin
					lo_q <= lo_q - chalf;
					hi_q <= hi_q - chalf;
				end
			end
			OP_CONV: res_q <= cres;
			OP_OUT: begin
				result_coord <= res_q;
				view_left    <= vpl_q;
				view_top     <= vpt_q;
				view_right   <= vpr_q;
				view_bottom  <= vpb_q;
				bad_request  <= bad_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.div_done = div_done;
		stat.req      = req_q;
		stat.vp_bad   = vp_bad;
		stat.ign      = ign_q;
	end
endmodule
`default_nettype wire

// File: sv/vpzm_ctrl.sv
`default_nettype none
module vpzm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire vpzm_pkg::dp_stat_t stat,
	output vpzm_pkg::dp_cmd_t       cmd
);
	import vpzm_pkg::*;

	state_t   state_q, state_d;
	div_sel_t dsel_q, dsel_d;
	logic     axis_q, axis_d;
	logic     ovalid_q, ovalid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dsel_q   <= DS_ZX;
			axis_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			dsel_q   <= dsel_d;
			axis_q   <= axis_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		dsel_d   = dsel_q;
		axis_d   = axis_q;
		ovalid_d = ovalid_q & ~out_ready;
		cmd.op   = OP_NONE;
		cmd.dsel = dsel_q;
		cmd.msel = MS_CONV;
		cmd.axis = axis_q;
		in_ready = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (stat.req)
					REQ_SETVP: state_d = ST_SETVP;
					REQ_PANZ: begin
						dsel_d  = DS_ZX;
						state_d = ST_DIV;
					end
					REQ_W2PX, REQ_W2PY, REQ_P2WX, REQ_P2WY: state_d = ST_VMUL;
					default: state_d = ST_DONE;
				endcase
			end
			ST_SETVP: begin
				cmd.op = OP_SETVP;
				if (stat.vp_bad) begin
					state_d = ST_DONE;
				end else begin
					dsel_d  = DS_PXS;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.op  = OP_DIV;
				state_d = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (stat.div_done) begin
					cmd.op = OP_STORE;
					case (dsel_q)
						DS_ZX: begin dsel_d = DS_ZY; state_d = ST_DIV; end
						DS_ZY: state_d = ST_ZMUL;
						DS_LO: begin dsel_d = DS_HI; state_d = ST_DIV; end
						DS_HI: state_d = stat.ign ? ST_PLACE : ST_CLR;
						DS_PXS: begin dsel_d = DS_PYS; state_d = ST_DIV; end
						DS_PYS: begin dsel_d = DS_WXS; state_d = ST_DIV; end
						DS_WXS: begin dsel_d = DS_WYS; state_d = ST_DIV; end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_ZMUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_ZOOM;
				state_d  = ST_ZSEL;
			end
			ST_ZSEL: begin
				cmd.op  = OP_ZSEL;
				axis_d  = 1'b0;
				state_d = ST_CMUL;
			end
			ST_CMUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_CENTER;
				dsel_d   = DS_LO;
				state_d  = ST_DIV;
			end
			ST_CLR: begin
				cmd.op  = OP_CLR;
				state_d = ST_CLL;
			end
			ST_CLL: begin
				cmd.op  = OP_CLL;
				state_d = ST_CLC;
			end
			ST_CLC: begin
				cmd.op  = OP_CLC;
				state_d = ST_PLACE;
			end
			ST_PLACE: begin
				cmd.op = OP_PLACE;
				if (!axis_q) begin
					axis_d  = 1'b1;
					state_d = ST_CMUL;
				end else begin
					dsel_d  = DS_PXS;
					state_d = ST_DIV;
				end
			end
			ST_VMUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MS_CONV;
				state_d  = ST_CONV;
			end
			ST_CONV: begin
				cmd.op  = OP_CONV;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// The result register may still hold an item that has not been taken.
				if (!ovalid_q || out_ready) begin
					cmd.op   = OP_OUT;
					ovalid_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = ovalid_q;
endmodule
`default_nettype wire

// File: sv/viewport_pan_zoom_mapper.sv
// Set viewport and pan/zoom run on the bit-serial divider: 4 divisions for set viewport,
// 10 for pan/zoom; conversions use no division. A refused set viewport does no division.
// Throughput: one item at a time; a new item is taken once the previous result is registered.
// Reset clears the viewport and the scales and returns the configuration to its defaults.
`default_nettype none
module viewport_pan_zoom_mapper #(
	parameter int FRAC_BITS = vpzm_pkg::FRAC_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [vpzm_pkg::REQ_W-1:0]         req_type,
	input  wire logic signed [vpzm_pkg::AIW-1:0]    coord_a,
	input  wire logic signed [vpzm_pkg::AIW-1:0]    coord_b,
	input  wire logic signed [vpzm_pkg::CW-1:0]     coord_c,
	input  wire logic signed [vpzm_pkg::CW-1:0]     coord_d,
	input  wire logic [vpzm_pkg::FAC_W-1:0]         zoom_factor,
	input  wire logic                               fit_world,
	input  wire logic                               ignore_borders,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [vpzm_pkg::CW-1:0]          result_coord,
	output logic signed [vpzm_pkg::CW-1:0]          view_left,
	output logic signed [vpzm_pkg::CW-1:0]          view_top,
	output logic signed [vpzm_pkg::CW-1:0]          view_right,
	output logic signed [vpzm_pkg::CW-1:0]          view_bottom,
	output logic                                    bad_request,
	input  wire logic                               cfg_we,
	input  wire logic [vpzm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [vpzm_pkg::CFG_W-1:0]         cfg_data
);
	import vpzm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	vpzm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	vpzm_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req_type),
		.coord_a        (coord_a),
		.coord_b        (coord_b),
		.coord_c        (coord_c),
		.coord_d        (coord_d),
		.zoom_factor    (zoom_factor),
		.fit_world      (fit_world),
		.ignore_borders (ignore_borders),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_coord   (result_coord),
		.view_left      (view_left),
		.view_top       (view_top),
		.view_right     (view_right),
		.view_bottom    (view_bottom),
		.bad_request    (bad_request)
	);
endmodule
`default_nettype wire
